// ----- hdl/pnr_pkg.sv -----
// ----------------------------------------------------------------------------
// pnr_pkg
// Shared widths and fixed-point helpers for the polynomial Newton root finder.
// ----------------------------------------------------------------------------
package pnr_pkg;

    localparam int VAL_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int TOL_W   = 31;
    localparam int STEPS_W = 7;
    localparam int DIV_W   = VAL_W + FRAC_W;

    typedef logic signed [VAL_W-1:0] t_q;

    function automatic t_q sat32(input logic signed [63:0] v);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
        if (v > hi) begin
            return t_q'(hi);
        end else if (v < lo) begin
            return t_q'(lo);
        end
        return t_q'(v);
    endfunction

    // round Q32.32 product to Q16.16, half up, saturated
    function automatic t_q qround(input logic signed [63:0] prod);
        logic signed [63:0] p;
        p = prod + 64'sd32768;
        return sat32(p >>> FRAC_W);
    endfunction

endpackage

// ----- hdl/pnr_ram.sv -----
// ----------------------------------------------------------------------------
// pnr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pnr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/pnr_div.sv -----
// ----------------------------------------------------------------------------
// pnr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pnr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pnr_pkg::DIV_W-1:0]    i_dividend,
    input  logic [pnr_pkg::VAL_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [pnr_pkg::DIV_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(pnr_pkg::DIV_W + 1);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [pnr_pkg::VAL_W:0]       r_rem;
    logic [pnr_pkg::DIV_W-1:0]     r_quo;
    logic [pnr_pkg::VAL_W-1:0]     r_dvs;
    logic [pnr_pkg::VAL_W:0]       rem_sh;
    logic                          fits;

    assign rem_sh     = {r_rem[pnr_pkg::VAL_W-1:0], r_quo[pnr_pkg::DIV_W-1]};
    assign fits       = rem_sh >= {1'b0, r_dvs};
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(pnr_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sh - {1'b0, r_dvs} : rem_sh;
            r_quo <= {r_quo[pnr_pkg::DIV_W-2:0], fits};
        end
    end

endmodule

// ----- hdl/poly_newton_root_finder.sv -----
// ----------------------------------------------------------------------------
// poly_newton_root_finder
// Newton-Raphson root search on a stored Q16.16 polynomial.
// ----------------------------------------------------------------------------
// Requests on the input channel carry one coefficient each, highest power
// first. Coefficient requests are taken back to back while idle; coefficients beyond
// MAX_DEGREE+1 are dropped and flagged. The request marked last also carries
// the start point and tolerance and starts the solve; the input stalls until
// the solve ends.
// Each Newton step reads the coefficient RAM once per coefficient and runs
// the Horner updates through one shared 32x32 multiplier in FETCH, M1, M2
// and M3 for each coefficient after the first, then a bit-serial division
// and an update state; a zero slope ends the solve in EVAL, past the Horner pass.
// A solve takes up to MAX_STEPS such steps and then loads the output
// register, and one result leaves on the output channel.
// The result sits in an output register; a stalled receiver holds it while
// new coefficient requests are still taken. A finished solve waits for that
// register to drain.
// Reset clears the coefficient count, the overflow flag and the output valid; the RAM is not cleared.
// ----------------------------------------------------------------------------
module poly_newton_root_finder #(
    parameter int MAX_DEGREE = 16,
    parameter int MAX_STEPS  = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_coefficient,
    input  logic                          i_last_coefficient,
    input  logic signed [31:0]            i_start_point,
    input  logic [pnr_pkg::TOL_W-1:0]     i_tolerance,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_root,
    output logic                          o_converged,
    output logic [pnr_pkg::STEPS_W-1:0]   o_steps_taken,
    output logic                          o_zero_slope,
    output logic                          o_too_many_coefficients
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD0 = 4'd1;
    localparam logic [3:0] ST_INIT  = 4'd2;
    localparam logic [3:0] ST_FETCH = 4'd3;
    localparam logic [3:0] ST_M1    = 4'd4;
    localparam logic [3:0] ST_M2    = 4'd5;
    localparam logic [3:0] ST_M3    = 4'd6;
    localparam logic [3:0] ST_EVAL  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_UPD   = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]              r_state;
    logic [CW-1:0]           r_count;
    logic                    r_ovf;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_k;
    logic                    r_ovf_res;
    logic [SW-1:0]           r_step;
    logic                    r_conv;
    logic                    r_flat;
    pnr_pkg::t_q             r_x;
    pnr_pkg::t_q             r_xn;
    logic [pnr_pkg::TOL_W-1:0] r_tol;
    pnr_pkg::t_q             r_sp;
    pnr_pkg::t_q             r_sd;
    pnr_pkg::t_q             r_c;
    pnr_pkg::t_q             r_dc;
    logic signed [63:0]      r_prod;

    logic                    accept;
    logic                    room;
    logic                    we;
    logic [31:0]             rd_data;
    pnr_pkg::t_q             cval;
    logic [CW-1:0]           deg;
    logic [CW-1:0]           dk;
    pnr_pkg::t_q             dcoef;
    pnr_pkg::t_q             mul_b;
    logic                    div_start;
    logic                    div_done;
    logic [pnr_pkg::DIV_W-1:0] div_quo;
    logic [31:0]             p_mag;
    logic [31:0]             d_mag;
    logic                    q_neg;
    logic signed [63:0]      q_ext;
    pnr_pkg::t_q             q_sat;
    logic signed [32:0]      delta;
    logic [32:0]             delta_abs;
    logic [SW-1:0]           step_inc;

    assign o_ready = r_state == ST_IDLE;
    assign accept  = i_valid && o_ready;
    assign room    = r_count < CW'(DEPTH);
    assign we      = accept && room;
    assign cval    = $signed(rd_data);
    assign deg     = r_n - 1'b1;
    assign dk      = deg - r_k;
    assign dcoef   = pnr_pkg::sat32(64'($signed({1'b0, dk})) * 64'(cval));
    assign mul_b   = (r_state == ST_M1) ? r_sp : r_sd;
    assign div_start = (r_state == ST_EVAL) && (r_sd != '0);
    assign p_mag   = r_sp[31] ? 32'(-r_sp) : 32'(r_sp);
    assign d_mag   = r_sd[31] ? 32'(-r_sd) : 32'(r_sd);
    assign q_ext   = q_neg ? -64'($signed({1'b0, div_quo})) : 64'($signed({1'b0, div_quo}));
    assign q_sat   = pnr_pkg::sat32(q_ext);
    assign delta     = 33'(r_xn) - 33'(r_x);
    assign delta_abs = delta[32] ? 33'(-delta) : 33'(delta);
    assign step_inc  = r_step + 1'b1;

    pnr_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_coefficient),
        .i_raddr(r_k[AW-1:0]),
        .o_rdata(rd_data)
    );

    pnr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend({p_mag, {pnr_pkg::FRAC_W{1'b0}}}),
        .i_divisor (d_mag),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != ST_DONE) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_last_coefficient) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_LOAD0;
                        end else if (room) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                ST_LOAD0: r_state <= ST_INIT;
                ST_INIT:  r_state <= (r_n == CW'(1)) ? ST_EVAL : ST_FETCH;
                ST_FETCH: r_state <= ST_M1;
                ST_M1:    r_state <= ST_M2;
                ST_M2:    r_state <= ST_M3;
                ST_M3:    r_state <= (r_k + 1'b1 < r_n) ? ST_FETCH : ST_EVAL;
                ST_EVAL:  r_state <= (r_sd == '0) ? ST_DONE : ST_DIV;
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (delta_abs < 33'(r_tol) || step_inc == SW'(MAX_STEPS)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_LOAD0;
                    end
                end
                ST_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept && i_last_coefficient) begin
                    r_n       <= room ? r_count + 1'b1 : r_count;
                    r_ovf_res <= r_ovf || !room;
                    r_x       <= i_start_point;
                    r_tol     <= i_tolerance;
                    r_step    <= '0;
                    r_conv    <= 1'b0;
                    r_flat    <= 1'b0;
                end
                r_k <= '0;
            end
            ST_LOAD0: r_k <= '0;
            ST_INIT: begin
                r_sp <= cval;
                r_sd <= (r_n >= CW'(2)) ? dcoef : '0;
                r_k  <= CW'(1);
            end
            ST_M1: begin
                r_c    <= cval;
                r_dc   <= dcoef;
                r_prod <= 64'(r_x) * 64'(mul_b);
            end
            ST_M2: begin
                r_sp   <= pnr_pkg::sat32(64'(pnr_pkg::qround(r_prod)) + 64'(r_c));
                r_prod <= 64'(r_x) * 64'(mul_b);
            end
            ST_M3: begin
                if (r_k < deg) begin
                    r_sd <= pnr_pkg::sat32(64'(pnr_pkg::qround(r_prod)) + 64'(r_dc));
                end
                r_k <= r_k + 1'b1;
            end
            ST_EVAL: begin
                q_neg <= r_sp[31] ^ r_sd[31];
                if (r_sd == '0) begin
                    r_flat <= 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    r_xn <= pnr_pkg::sat32(64'(r_x) - 64'(q_sat));
                end
            end
            ST_UPD: begin
                r_step <= step_inc;
                r_x    <= r_xn;
                r_conv <= delta_abs < 33'(r_tol);
                r_k    <= '0;
            end
            ST_DONE: begin
                if (!o_valid || i_ready) begin
                    o_root                  <= r_x;
                    o_converged             <= r_conv;
                    o_steps_taken           <= (32'(r_step) > 32'(7'h7f)) ?
                                               7'h7f : pnr_pkg::STEPS_W'(r_step);
                    o_zero_slope            <= r_flat;
                    o_too_many_coefficients <= r_ovf_res;
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_n != '0))
        else $error("solve running with empty polynomial");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("coefficient count beyond store depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (32'(r_step) <= 32'(MAX_STEPS)))
        else $error("step count beyond limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("division finished outside divide state");

endmodule

// ----- test/poly_newton_root_finder_tb.sv -----
// ----------------------------------------------------------------------------
// poly_newton_root_finder_tb
// Loads random and directed polynomials, predicts each Newton solve in the
// bench and checks every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module poly_newton_root_finder_tb;

    localparam int MAX_DEGREE = 16;
    localparam int MAX_STEPS  = 100;
    localparam int DEPTH      = MAX_DEGREE + 1;

    typedef struct packed {
        logic signed [31:0] root;
        logic               converged;
        logic [6:0]         steps;
        logic               zero_slope;
        logic               dropped;
    } t_solve;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    logic signed [31:0]              i_coefficient;
    logic                            i_last_coefficient;
    logic signed [31:0]              i_start_point;
    logic [pnr_pkg::TOL_W-1:0]       i_tolerance;
    logic                            o_valid;
    logic                            i_ready;
    logic signed [31:0]              o_root;
    logic                            o_converged;
    logic [pnr_pkg::STEPS_W-1:0]     o_steps_taken;
    logic                            o_zero_slope;
    logic                            o_too_many_coefficients;

    poly_newton_root_finder #(.MAX_DEGREE(MAX_DEGREE), .MAX_STEPS(MAX_STEPS)) dut (.*);

    logic signed [31:0] coef_mem [DEPTH];
    int                 coef_cnt;
    logic               coef_over;
    t_solve             pending_solves[$];
    int                 errors;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fxmul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd32768;
        return clamp32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] horner_val(input logic signed [31:0] x);
        logic signed [31:0] s;
        s = coef_mem[0];
        for (int k = 1; k < coef_cnt; k++) s = clamp32(64'(fxmul(x, s)) + 64'(coef_mem[k]));
        return s;
    endfunction

    function automatic logic signed [31:0] horner_slope(input logic signed [31:0] x);
        logic signed [31:0] s;
        logic signed [31:0] dc;
        int deg;
        deg = coef_cnt - 1;
        if (coef_cnt < 2) return 0;
        s = clamp32(64'(deg) * 64'(coef_mem[0]));
        for (int k = 1; k < deg; k++) begin
            dc = clamp32(64'(deg - k) * 64'(coef_mem[k]));
            s = clamp32(64'(fxmul(x, s)) + 64'(dc));
        end
        return s;
    endfunction

    function automatic t_solve solve_newton(input logic signed [31:0] x0,
                                            input logic [30:0] tol);
        t_solve r;
        logic signed [31:0] x, d, p, xn;
        logic signed [63:0] q, dl;
        int steps;
        x = x0;
        steps = 0;
        r = '0;
        for (int i = 0; i < MAX_STEPS; i++) begin
            d = horner_slope(x);
            if (d == 0) begin
                r.zero_slope = 1'b1;
                break;
            end
            p = horner_val(x);
            q = (64'(p) * 64'sd65536) / 64'(d);
            xn = clamp32(64'(x) - 64'(clamp32(q)));
            steps = i + 1;
            dl = 64'(xn) - 64'(x);
            if (dl < 0) dl = -dl;
            x = xn;
            if (dl < 64'($unsigned(tol))) begin
                r.converged = 1'b1;
                break;
            end
        end
        r.root = x;
        r.steps = 7'(steps);
        r.dropped = coef_over;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task automatic send_coef(input logic signed [31:0] c, input logic last,
                             input logic signed [31:0] x0, input logic [30:0] tol);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_coefficient      <= c;
        i_last_coefficient <= last;
        i_start_point      <= x0;
        i_tolerance        <= tol;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (coef_cnt < DEPTH) begin
            coef_mem[coef_cnt] = c;
            coef_cnt++;
        end else begin
            coef_over = 1'b1;
        end
        if (last) begin
            pending_solves.push_back(solve_newton(x0, tol));
            coef_cnt  = 0;
            coef_over = 1'b0;
        end
    endtask

    initial begin
        t_solve w;
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 7);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (pending_solves.size() == 0) begin
                report_mismatch("unexpected result", o_root, 0);
            end else begin
                w = pending_solves.pop_front();
                if (o_root !== w.root) report_mismatch("root", o_root, w.root);
                if (o_converged !== w.converged)
                    report_mismatch("converged", o_converged, w.converged);
                if (o_steps_taken !== w.steps) report_mismatch("steps", o_steps_taken, w.steps);
                if (o_zero_slope !== w.zero_slope)
                    report_mismatch("zero_slope", o_zero_slope, w.zero_slope);
                if (o_too_many_coefficients !== w.dropped)
                    report_mismatch("too_many", o_too_many_coefficients, w.dropped);
            end
        end
    end

    function automatic logic signed [31:0] rand_small();
        return $signed($urandom_range(0, 32'h000c0000)) - 32'sh00060000;
    endfunction

    function automatic logic signed [31:0] rand_any();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return rand_small();
        endcase
    endfunction

    function automatic logic [30:0] rand_tol();
        case ($urandom_range(0, 3))
            0: return 31'($urandom());
            1: return 31'($urandom_range(0, 16));
            default: return 31'($urandom_range(0, 2048));
        endcase
    endfunction

    task automatic send_poly(input int n, input logic signed [31:0] x0,
                             input logic [30:0] tol, input bit wild);
        for (int i = 0; i < n; i++)
            send_coef(wild ? rand_any() : rand_small(), i == n - 1, x0, tol);
    endtask

    task automatic test_extremes();
        send_coef(32'sh7fffffff, 1'b1, 32'sh7fffffff, 31'h7fffffff);
        send_coef(32'sh00010000, 1'b0, 0, 0);
        send_coef(32'sh80000000, 1'b1, 32'sh80000000, 0);
        send_coef(32'sh00010000, 1'b0, 0, 0);
        send_coef(32'sh00000000, 1'b0, 0, 0);
        send_coef(32'shfffc0000, 1'b1, 32'sh00030000, 31'd16);
    endtask

    task automatic test_zero_slope();
        send_coef(32'sh00010000, 1'b0, 0, 0);
        send_coef(32'sh00000000, 1'b0, 0, 0);
        send_coef(32'sh00010000, 1'b1, 32'sh00000000, 31'd1);
    endtask

    task automatic test_step_limit();
        send_coef(32'sh00010000, 1'b0, 0, 0);
        send_coef(32'sh00000000, 1'b0, 0, 0);
        send_coef(32'sh00010000, 1'b1, 32'sh00008000, 31'd0);
    endtask

    task automatic test_store_full();
        send_poly(DEPTH + 3, 32'sh00008000, 31'd64, 1'b0);
        send_poly(DEPTH, 32'sh00010000, 31'd64, 1'b0);
    endtask

    task automatic test_random();
        int sent, n;
        sent = 0;
        while (sent < 1100) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, DEPTH + 4)
                                            : $urandom_range(1, 6);
            send_poly(n, ($urandom_range(0, 3) == 0) ? rand_any() : rand_small(),
                      rand_tol(), $urandom_range(0, 4) == 0);
            sent += n;
        end
    endtask

    initial begin
        errors = 0;
        coef_cnt = 0;
        coef_over = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_coefficient = '0;
        i_last_coefficient = 1'b0;
        i_start_point = '0;
        i_tolerance = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_zero_slope();
        test_step_limit();
        test_store_full();
        test_random();
        i_valid <= 1'b0;
        while (pending_solves.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("poly_newton_root_finder test passed");
        end else begin
            $display("poly_newton_root_finder test failed");
        end
        $finish;
    end

    initial begin
        #80000000;
        $display("poly_newton_root_finder test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/pnr_pkg.sv
hdl/pnr_ram.sv
hdl/pnr_div.sv
hdl/poly_newton_root_finder.sv
test/poly_newton_root_finder_tb.sv
